>>> hw/rtl/q2e_pkg.sv
// ============================================================================
// q2e_pkg
// Shared types, constants and the CORDIC angle table for the quaternion to
// Euler angle converter.
// ============================================================================
package q2e_pkg;

    localparam int CordicIterDef = 16;
    localparam int QuatFracDef   = 14;
    localparam int TabLen        = 24;
    localparam int AngFrac       = 8;
    // CORDIC operand width: Q30 pitch operands and quaternion products fit here
    localparam int CW            = 66;
    localparam int ZW            = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_ROLL_LD,
        ST_ROLL_RUN,
        ST_SQRT_LD,
        ST_SQRT_RUN,
        ST_PITCH_LD,
        ST_PITCH_RUN,
        ST_YAW_LD,
        ST_YAW_RUN,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_ROLL,
        SEL_PITCH,
        SEL_YAW
    } t_sel;

    typedef struct packed {
        logic load_in;
        logic calc_prod;
        logic cordic_load;
        logic cordic_step;
        logic sqrt_load;
        logic sqrt_step;
        logic store;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
        logic sqrt_done;
    } t_status;

    function automatic logic [ZW-1:0] atan_tab(input logic [4:0] idx);
        logic [ZW-1:0] r;
        unique case (idx)
            5'd0:  r = 24'd1152000;
            5'd1:  r = 24'd680065;
            5'd2:  r = 24'd359328;
            5'd3:  r = 24'd182400;
            5'd4:  r = 24'd91554;
            5'd5:  r = 24'd45822;
            5'd6:  r = 24'd22916;
            5'd7:  r = 24'd11459;
            5'd8:  r = 24'd5730;
            5'd9:  r = 24'd2865;
            5'd10: r = 24'd1432;
            5'd11: r = 24'd716;
            5'd12: r = 24'd358;
            5'd13: r = 24'd179;
            5'd14: r = 24'd90;
            5'd15: r = 24'd45;
            5'd16: r = 24'd22;
            5'd17: r = 24'd11;
            5'd18: r = 24'd6;
            5'd19: r = 24'd3;
            5'd20: r = 24'd1;
            5'd21: r = 24'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/q2e_ctrl.sv
// ============================================================================
// q2e_ctrl
// Sequencer: products, roll CORDIC, square root, pitch CORDIC, yaw CORDIC.
// ============================================================================
module q2e_ctrl
    import q2e_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_PROD;
            ST_PROD:      n_state = ST_ROLL_LD;
            ST_ROLL_LD:   n_state = ST_ROLL_RUN;
            ST_ROLL_RUN:  if (i_status.cordic_done) n_state = ST_SQRT_LD;
            ST_SQRT_LD:   n_state = ST_SQRT_RUN;
            ST_SQRT_RUN:  if (i_status.sqrt_done) n_state = ST_PITCH_LD;
            ST_PITCH_LD:  n_state = ST_PITCH_RUN;
            ST_PITCH_RUN: if (i_status.cordic_done) n_state = ST_YAW_LD;
            ST_YAW_LD:    n_state = ST_YAW_RUN;
            ST_YAW_RUN:   if (i_status.cordic_done) n_state = ST_OUT;
            ST_OUT:       if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.sel   = SEL_ROLL;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_PROD:     o_cmd.calc_prod = 1'b1;
            ST_ROLL_LD: begin
                o_cmd.cordic_load = 1'b1;
                o_cmd.sel         = SEL_ROLL;
            end
            ST_ROLL_RUN: begin
                o_cmd.sel         = SEL_ROLL;
                o_cmd.cordic_step = 1'b1;
                o_cmd.store       = i_status.cordic_done;
            end
            ST_SQRT_LD:  o_cmd.sqrt_load = 1'b1;
            ST_SQRT_RUN: o_cmd.sqrt_step = 1'b1;
            ST_PITCH_LD: begin
                o_cmd.cordic_load = 1'b1;
                o_cmd.sel         = SEL_PITCH;
            end
            ST_PITCH_RUN: begin
                o_cmd.sel         = SEL_PITCH;
                o_cmd.cordic_step = 1'b1;
                o_cmd.store       = i_status.cordic_done;
            end
            ST_YAW_LD: begin
                o_cmd.cordic_load = 1'b1;
                o_cmd.sel         = SEL_YAW;
            end
            ST_YAW_RUN: begin
                o_cmd.sel         = SEL_YAW;
                o_cmd.cordic_step = 1'b1;
                o_cmd.store       = i_status.cordic_done;
            end
            ST_OUT:      o_out_valid = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/q2e_dpath.sv
// ============================================================================
// q2e_dpath
// Products, shared vectoring CORDIC, bit-serial square root, result regs.
// ============================================================================
module q2e_dpath
    import q2e_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDef,
    parameter int QUAT_FRAC_BITS    = QuatFracDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic signed [15:0] o_roll_cdeg,
    output logic signed [14:0] o_pitch_cdeg,
    output logic        [15:0] o_yaw_cdeg,
    output logic               o_roll_held,
    output logic               o_yaw_held
);

    localparam int F2    = 2 * QUAT_FRAC_BITS;
    localparam int NITER = (CORDIC_ITERATIONS < TabLen) ? CORDIC_ITERATIONS : TabLen;
    localparam int SQW   = 31;                  // sqrt result bits (<= 2^30)
    localparam int SQN   = 31;                  // 2-bit steps over 62-bit radicand

    localparam logic signed [CW-1:0] HALF = CW'(64'sd1) <<< (F2 - 1);
    localparam logic signed [CW-1:0] ONE  = CW'(64'sd1) <<< F2;
    localparam logic signed [ZW-1:0] Z180 = ZW'(18000 * 256);

    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic signed [CW-1:0] r_rn, r_rd, r_yn, r_yd, r_s;

    // products: nine combinational multiplies, sums registered on calc_prod
    logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_xz, p_xy, p_wz, p_zz;
    assign p_wx = r_w * r_x;
    assign p_yz = r_y * r_z;
    assign p_xx = r_x * r_x;
    assign p_yy = r_y * r_y;
    assign p_wy = r_w * r_y;
    assign p_xz = r_x * r_z;
    assign p_xy = r_x * r_y;
    assign p_wz = r_w * r_z;
    assign p_zz = r_z * r_z;

    logic signed [CW-1:0] arg, argc, sval;
    always_comb begin
        arg  = (CW'(p_wy) - CW'(p_xz)) <<< 1;
        argc = (arg > ONE) ? ONE : ((arg < -ONE) ? -ONE : arg);
        if (F2 > 30) sval = argc >>> (F2 - 30);
        else         sval = argc <<< (30 - F2);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_w <= i_quat_w;
            r_x <= i_quat_x;
            r_y <= i_quat_y;
            r_z <= i_quat_z;
        end
        if (i_cmd.calc_prod) begin
            r_rn <= CW'(p_wx) + CW'(p_yz);
            r_rd <= HALF - CW'(p_xx) - CW'(p_yy);
            r_yn <= CW'(p_xy) + CW'(p_wz);
            r_yd <= HALF - CW'(p_yy) - CW'(p_zz);
            r_s  <= sval;
        end
    end

    // ---------------- square root of 2^60 - s^2 ----------------
    logic [61:0]     r_rem;
    logic [SQW-1:0]  r_root;
    logic [4:0]      r_scnt;
    logic [29:0]     mag;
    logic [59:0]     magsq;
    assign mag   = r_s[CW-1] ? 30'(-r_s) : 30'(r_s);
    // |s| <= 2^30; 2^30 itself gives radicand 0
    assign magsq = 60'(mag) * 60'(mag);

    // restoring sqrt: partial remainder in r_pr, radicand bits shifted in
    logic [33:0] r_pr;
    logic [33:0] pr_sh;
    logic [33:0] pr_tr;
    assign pr_sh = {r_pr[31:0], r_rem[61:60]};
    assign pr_tr = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_load) begin
            r_rem  <= (r_s[CW-1:30] != '0 && !r_s[CW-1]) || (mag == 30'd0 && r_s[30])
                      ? 62'd0 : 62'(61'(61'd1 << 60) - 61'(magsq));
            r_root <= '0;
            r_pr   <= '0;
            r_scnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rem <= {r_rem[59:0], 2'b00};
            if (pr_sh >= pr_tr) begin
                r_pr   <= pr_sh - pr_tr;
                r_root <= {r_root[SQW-2:0], 1'b1};
            end else begin
                r_pr   <= pr_sh;
                r_root <= {r_root[SQW-2:0], 1'b0};
            end
            r_scnt <= r_scnt + 5'd1;
        end
    end
    assign o_status.sqrt_done = i_cmd.sqrt_step && (r_scnt == 5'(SQN - 1));

    // ---------------- vectoring CORDIC ----------------
    logic signed [CW+1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic [4:0]           r_ci;
    logic signed [CW-1:0] ld_n, ld_d;
    always_comb begin
        unique case (i_cmd.sel)
            SEL_ROLL:  begin ld_n = r_rn; ld_d = r_rd; end
            SEL_PITCH: begin ld_n = r_s;  ld_d = CW'({1'b0, r_root}); end
            SEL_YAW:   begin ld_n = r_yn; ld_d = r_yd; end
            default:   begin ld_n = r_rn; ld_d = r_rd; end
        endcase
    end

    logic signed [CW+1:0] dx, dy;
    logic signed [ZW-1:0] tab;
    assign dx  = r_cy >>> r_ci;
    assign dy  = r_cx >>> r_ci;
    assign tab = $signed(atan_tab(r_ci));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_load) begin
            r_ci <= '0;
            if (ld_d[CW-1]) begin
                r_cx <= -(CW+2)'(ld_d);
                r_cy <= -(CW+2)'(ld_n);
                r_cz <= (-ld_n <= 0) ? Z180 : -Z180;
            end else begin
                r_cx <= (CW+2)'(ld_d);
                r_cy <= (CW+2)'(ld_n);
                r_cz <= '0;
            end
        end else if (i_cmd.cordic_step) begin
            r_ci <= r_ci + 5'd1;
            if (r_cy > 0) begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + tab;
            end else begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - tab;
            end
        end
    end
    assign o_status.cordic_done = i_cmd.cordic_step && (r_ci == 5'(NITER - 1));

    // final rotation folded into rounding: use next z value
    logic signed [ZW-1:0] z_fin;
    logic signed [ZW-AngFrac-1:0] ang;
    logic signed [17:0] ang18;
    assign z_fin = (r_cy > 0) ? r_cz + tab : r_cz - tab;
    assign ang   = (ZW-AngFrac)'((z_fin + ZW'(128)) >>> AngFrac);
    assign ang18 = 18'(ang);

    logic signed [17:0] roll_c, pitch_c, yaw_c;
    always_comb begin
        roll_c  = (ang18 > 18000) ? 18'sd18000 : ((ang18 < -18000) ? -18'sd18000 : ang18);
        pitch_c = (ang18 > 9000)  ? 18'sd9000  : ((ang18 < -9000)  ? -18'sd9000  : ang18);
        yaw_c   = ang18 + 18'sd18000;
        if (yaw_c < 0)      yaw_c = '0;
        if (yaw_c > 36000)  yaw_c = 18'sd36000;
    end

    logic roll_hold, yaw_hold;
    assign roll_hold = (r_rn == '0) || (r_rd == '0);
    assign yaw_hold  = (r_yn == '0) || (r_yd == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_roll_cdeg <= '0;
            o_yaw_cdeg  <= '0;
        end else if (i_cmd.store) begin
            unique case (i_cmd.sel)
                SEL_ROLL: begin
                    o_roll_held <= roll_hold;
                    if (!roll_hold) o_roll_cdeg <= 16'(roll_c);
                end
                SEL_PITCH: o_pitch_cdeg <= 15'(pitch_c);
                SEL_YAW: begin
                    o_yaw_held <= yaw_hold;
                    if (!yaw_hold) o_yaw_cdeg <= 16'(yaw_c);
                end
                default: o_pitch_cdeg <= o_pitch_cdeg;
            endcase
        end
    end

endmodule

>>> hw/rtl/quaternion_to_euler_angles_core.sv
// ============================================================================
// quaternion_to_euler_angles_core
// Processes one item at a time: a new input beat is taken only after the result
// beat has been accepted; the pace is set by the shared CORDIC and the 31-step
// bit-serial square root.
// Synchronous active-low reset clears the sequencer and last roll/yaw to 0.
// ============================================================================
module quaternion_to_euler_angles_core
    import q2e_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CordicIterDef,
    parameter int QUAT_FRAC_BITS    = QuatFracDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // roll_cdeg, pitch_cdeg, yaw_cdeg, zero fill
    output logic [1:0]  m_axis_tuser   // roll_held, yaw_held
);

    t_cmd    cmd;
    t_status status;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic        [15:0] yaw;
    logic               rh, yh;

    q2e_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    q2e_dpath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .QUAT_FRAC_BITS    (QUAT_FRAC_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_quat_w     (s_axis_tdata[15:0]),
        .i_quat_x     (s_axis_tdata[31:16]),
        .i_quat_y     (s_axis_tdata[47:32]),
        .i_quat_z     (s_axis_tdata[63:48]),
        .o_roll_cdeg  (roll),
        .o_pitch_cdeg (pitch),
        .o_yaw_cdeg   (yaw),
        .o_roll_held  (rh),
        .o_yaw_held   (yh)
    );

    assign m_axis_tdata = {1'b0, yaw, pitch, roll};
    assign m_axis_tuser = {yh, rh};

    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result pending");
    a_out_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result right after accept");
    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.cordic_load, cmd.sqrt_load, cmd.sqrt_step, cmd.calc_prod}))
        else $error("conflicting datapath commands");

endmodule
